### rtl/imm_pkg.sv
// Shared types and constants of the integer matrix multiplier.
package imm_pkg;

    localparam int CFG_W      = 4;
    localparam int CIDX_W     = 2;
    localparam int IDX_PORT_W = 3;
    localparam int OP_W       = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_ROWS_OF_A  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLS_OF_B  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_WALK
    } t_seq_state;

    // One read beat of the walk, carried alongside the store read data.
    typedef struct packed {
        logic                  first;
        logic                  last_t;
        logic                  zero;
        logic                  last_elem;
        logic [IDX_PORT_W-1:0] row;
        logic [IDX_PORT_W-1:0] col;
    } t_beat;

endpackage

### rtl/imm_store.sv
// Synchronous element store with one write port and one registered read port.
module imm_store #(
    parameter int DATA_WIDTH = 16,
    parameter int DEPTH      = 64,
    parameter int ADDR_W     = 6
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/imm_seq.sv
// Walk sequencer: steps row, column and inner index and issues store reads.
module imm_seq import imm_pkg::*; #(
    parameter int MAX_DIM = 8,
    parameter int DIM_W   = 4,
    parameter int IDX_W   = 3,
    parameter int ADDR_W  = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_start,
    input  logic [DIM_W-1:0]  i_nr,
    input  logic [DIM_W-1:0]  i_nk,
    input  logic [DIM_W-1:0]  i_nc,
    output logic              o_busy,
    output logic              o_beat_valid,
    output t_beat             o_beat,
    output logic [ADDR_W-1:0] o_a_addr,
    output logic [ADDR_W-1:0] o_b_addr
);

    t_seq_state       r_state;
    t_seq_state       n_state;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_t;
    logic [DIM_W-1:0] r_nr;
    logic [DIM_W-1:0] r_nk;
    logic [DIM_W-1:0] r_nc;
    logic             w_zero;
    logic             w_last_t;
    logic             w_last_j;
    logic             w_last_i;
    logic             w_step;
    logic             w_done;

    assign w_zero   = (r_nk == '0);
    assign w_last_t = w_zero || ((DIM_W'(r_t) + DIM_W'(1)) == r_nk);
    assign w_last_j = ((DIM_W'(r_j) + DIM_W'(1)) == r_nc);
    assign w_last_i = ((DIM_W'(r_i) + DIM_W'(1)) == r_nr);
    assign w_step   = (r_state == SEQ_WALK) && i_en;
    assign w_done   = w_step && w_last_t && w_last_j && w_last_i;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_WALK;
                end
            end
            SEQ_WALK: begin
                if (w_done) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_comb begin
        o_busy       = 1'b0;
        o_beat_valid = 1'b0;
        unique case (r_state)
            SEQ_IDLE: begin
                o_busy       = 1'b0;
                o_beat_valid = 1'b0;
            end
            SEQ_WALK: begin
                o_busy       = 1'b1;
                o_beat_valid = 1'b1;
            end
            default: begin
                o_busy       = 1'b0;
                o_beat_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_t     <= '0;
            r_nr    <= '0;
            r_nk    <= '0;
            r_nc    <= '0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_i  <= '0;
                r_j  <= '0;
                r_t  <= '0;
                r_nr <= i_nr;
                r_nk <= i_nk;
                r_nc <= i_nc;
            end else if (w_step) begin
                if (w_last_t) begin
                    r_t <= '0;
                    if (w_last_j) begin
                        r_j <= '0;
                        if (!w_last_i) begin
                            r_i <= r_i + IDX_W'(1);
                        end
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end else begin
                    r_t <= r_t + IDX_W'(1);
                end
            end
        end
    end

    assign o_a_addr = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_t));
    assign o_b_addr = ADDR_W'(int'(r_t) * MAX_DIM + int'(r_j));

    always_comb begin
        o_beat.first     = (r_t == '0);
        o_beat.last_t    = w_last_t;
        o_beat.zero      = w_zero;
        o_beat.last_elem = w_last_j && w_last_i;
        o_beat.row       = IDX_PORT_W'(r_i);
        o_beat.col       = IDX_PORT_W'(r_j);
    end

endmodule

### rtl/imm_mac.sv
// Multiply-accumulate pipeline with the result output register.
module imm_mac import imm_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int PROD_W     = 35
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_beat_valid,
    input  t_beat                        i_beat,
    input  logic signed [DATA_WIDTH-1:0] i_rd_a,
    input  logic signed [DATA_WIDTH-1:0] i_rd_b,
    output logic                         o_valid,
    output logic [IDX_PORT_W-1:0]        o_out_row,
    output logic [IDX_PORT_W-1:0]        o_out_col,
    output logic signed [PROD_W-1:0]     o_product_value,
    output logic                         o_last
);

    logic                           r_s1_valid;
    t_beat                          r_s1_beat;
    logic                           r_s2_valid;
    t_beat                          r_s2_beat;
    logic signed [2*DATA_WIDTH-1:0] w_prod;
    logic signed [2*DATA_WIDTH-1:0] r_prod;
    logic signed [PROD_W-1:0]       r_acc;
    logic signed [PROD_W-1:0]       n_acc;
    logic signed [PROD_W-1:0]       w_prod_ext;
    logic                           r_out_valid;
    logic [IDX_PORT_W-1:0]          r_out_row;
    logic [IDX_PORT_W-1:0]          r_out_col;
    logic signed [PROD_W-1:0]       r_out_value;
    logic                           r_out_last;

    // The product is formed on its own so that both operands stay signed.
    assign w_prod     = i_rd_a * i_rd_b;
    assign w_prod_ext = PROD_W'(r_prod);
    assign n_acc      = (r_s2_beat.first ? '0 : r_acc) + w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid  <= i_beat_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_beat.last_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_beat <= i_beat;
            r_s2_beat <= r_s1_beat;
            // An empty inner dimension must give zero whatever the stores hold.
            r_prod    <= r_s1_beat.zero ? '0 : w_prod;
            if (r_s2_valid) begin
                r_acc <= n_acc;
            end
            if (r_s2_valid && r_s2_beat.last_t) begin
                r_out_row   <= r_s2_beat.row;
                r_out_col   <= r_s2_beat.col;
                r_out_value <= n_acc;
                r_out_last  <= r_s2_beat.last_elem;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;

endmodule

### rtl/integer_matrix_multiply.sv
// Top level of the integer matrix multiplier: configuration, loads, walk and results.
// Loads go straight into the stores and the block accepts one request per cycle between computes.
// A compute request holds intake for its whole walk, including any result stall cycles;
// its C elements leave in row-major order via the read, product and output registers.
// Reset is synchronous and active low: dimension registers go to 8, the pipeline empties,
// and the element stores are not cleared (no clearing pass; no wait after reset).
module integer_matrix_multiply import imm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16,
    localparam int PROD_W    = 2 * DATA_WIDTH + $clog2(MAX_DIM)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [OP_W-1:0]              i_operation,
    input  logic [IDX_PORT_W-1:0]        i_row_index,
    input  logic [IDX_PORT_W-1:0]        i_col_index,
    input  logic signed [DATA_WIDTH-1:0] i_element_value,
    // Result channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [IDX_PORT_W-1:0]        o_out_row,
    output logic [IDX_PORT_W-1:0]        o_out_col,
    output logic signed [PROD_W-1:0]     o_product_value,
    output logic                         o_last,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CIDX_W-1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    // Dimension values run from 0 to MAX_DIM; indices from 0 to MAX_DIM-1.
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW     = (DIM_W > IDX_PORT_W) ? DIM_W : IDX_PORT_W;

    logic [CFG_W-1:0]             r_rows_of_a;
    logic [CFG_W-1:0]             r_inner_size;
    logic [CFG_W-1:0]             r_cols_of_b;
    logic [DIM_W-1:0]             w_nr;
    logic [DIM_W-1:0]             w_nk;
    logic [DIM_W-1:0]             w_nc;
    logic                         w_in_acc;
    logic                         w_a_ok;
    logic                         w_b_ok;
    logic                         w_wr_en_a;
    logic                         w_wr_en_b;
    logic [ADDR_W-1:0]            w_wr_addr;
    logic                         w_start;
    logic                         w_adv;
    logic                         w_busy;
    logic                         w_beat_valid;
    t_beat                        w_beat;
    logic [ADDR_W-1:0]            w_a_addr;
    logic [ADDR_W-1:0]            w_b_addr;
    logic signed [DATA_WIDTH-1:0] w_rd_a;
    logic signed [DATA_WIDTH-1:0] w_rd_b;

    // Configuration registers. The port never pushes back; an index beyond the
    // three dimension registers is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_of_a  <= CFG_RESET;
            r_inner_size <= CFG_RESET;
            r_cols_of_b  <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROWS_OF_A:  r_rows_of_a  <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_OF_B:  r_cols_of_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A dimension register above MAX_DIM behaves as MAX_DIM.
    assign w_nr = ({1'b0, r_rows_of_a} > (CFG_W + 1)'(MAX_DIM)) ?
                  DIM_W'(MAX_DIM) : DIM_W'(r_rows_of_a);
    assign w_nk = ({1'b0, r_inner_size} > (CFG_W + 1)'(MAX_DIM)) ?
                  DIM_W'(MAX_DIM) : DIM_W'(r_inner_size);
    assign w_nc = ({1'b0, r_cols_of_b} > (CFG_W + 1)'(MAX_DIM)) ?
                  DIM_W'(MAX_DIM) : DIM_W'(r_cols_of_b);

    // Intake is held for the whole walk. Store writes and walk reads therefore
    // never overlap, which is the interlock that keeps every read consistent.
    assign o_stall  = w_busy;
    assign w_in_acc = i_valid && !o_stall;

    // A load outside the configured sizes is dropped without a result.
    assign w_a_ok = (IW'(i_row_index) < IW'(w_nr)) && (IW'(i_col_index) < IW'(w_nk));
    assign w_b_ok = (IW'(i_row_index) < IW'(w_nk)) && (IW'(i_col_index) < IW'(w_nc));

    assign w_wr_addr = ADDR_W'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
    assign w_wr_en_a = w_in_acc && (i_operation == OP_LOAD_A) && w_a_ok;
    assign w_wr_en_b = w_in_acc && (i_operation == OP_LOAD_B) && w_b_ok;

    // An empty result matrix starts no walk; the compute request is simply taken.
    assign w_start = w_in_acc && (i_operation == OP_COMPUTE) &&
                     (w_nr != '0) && (w_nc != '0);

    // The whole read and accumulate pipeline moves together and freezes only
    // while a finished element waits in the output register and is stalled.
    assign w_adv = !(o_valid && i_stall);

    imm_seq #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .IDX_W   (IDX_W),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_start      (w_start),
        .i_nr         (w_nr),
        .i_nk         (w_nk),
        .i_nc         (w_nc),
        .o_busy       (w_busy),
        .o_beat_valid (w_beat_valid),
        .o_beat       (w_beat),
        .o_a_addr     (w_a_addr),
        .o_b_addr     (w_b_addr)
    );

    imm_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en_a),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_element_value),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_a_addr),
        .o_rd_data (w_rd_a)
    );

    imm_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en_b),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_element_value),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_b_addr),
        .o_rd_data (w_rd_b)
    );

    imm_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .PROD_W     (PROD_W)
    ) u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv),
        .i_beat_valid    (w_beat_valid),
        .i_beat          (w_beat),
        .i_rd_a          (w_rd_a),
        .i_rd_b          (w_rd_b),
        .o_valid         (o_valid),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

    // No store is written while the walk is reading.
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en_a || w_wr_en_b) |-> !w_busy)
        else $error("element store written during a walk");

    // The element marked last sits at the bottom right corner of C.
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |->
        ((o_out_row == IDX_PORT_W'(w_nr - DIM_W'(1))) &&
         (o_out_col == IDX_PORT_W'(w_nc - DIM_W'(1)))))
        else $error("last marker away from the final element");

    // A compute request that is taken starts the walk on the next cycle.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_busy)
        else $error("walk did not start after a compute request");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

### tb/sv/integer_matrix_multiply_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the integer matrix multiplier: directed and random requests checked by a built-in predictor.
module integer_matrix_multiply_tb;
    import imm_pkg::*;

    localparam int MAX_DIM        = 8;
    localparam int DATA_W         = 16;
    localparam int PROD_W         = 2 * DATA_W + $clog2(MAX_DIM);
    localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
    // A load is written on the edge that takes it and every result of a walk is back before the
    // block drains, so a handful of quiet cycles is ample before touching the registers.
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    // Cycles in which nothing at all is accepted before the run is declared hung. The
    // slowest legal stretch is a full 8x8x8 walk plus the hold-off of the result sink.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 200;
    // Requests sent by the random rounds; the directed tests before them send about 40.
    localparam int RANDOM_REQUESTS = 90;

    // The package names three operations and three registers; the spare codes are named here.
    localparam logic [OP_W-1:0]   OP_UNUSED       = 2'd3;
    localparam logic [CIDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    localparam logic [DATA_W-1:0] VAL_MIN       = 16'h8000;
    localparam logic [DATA_W-1:0] VAL_MAX       = 16'h7FFF;
    localparam logic [CFG_W-1:0]  DIM_CEILING   = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [IDX_PORT_W-1:0] row;
        logic [IDX_PORT_W-1:0] col;
        logic [DATA_W-1:0]     value;
    } t_request;

    typedef struct packed {
        logic [IDX_PORT_W-1:0] row;
        logic [IDX_PORT_W-1:0] col;
        logic [PROD_W-1:0]     value;
        logic                  last;
    } t_c_elem;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [OP_W-1:0]          i_operation;
    logic [IDX_PORT_W-1:0]    i_row_index;
    logic [IDX_PORT_W-1:0]    i_col_index;
    logic signed [DATA_W-1:0] i_element_value;
    logic                     o_valid;
    logic                     i_stall;
    logic [IDX_PORT_W-1:0]    o_out_row;
    logic [IDX_PORT_W-1:0]    o_out_col;
    logic signed [PROD_W-1:0] o_product_value;
    logic                     o_last;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CIDX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;

    integer_matrix_multiply #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Predictor state: the three dimension registers and both element stores, as the
    // block should hold them after every accepted request and register write.
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         inner_reg;
    logic [CFG_W-1:0]         cols_reg;
    logic signed [DATA_W-1:0] a_store [STORE_DEPTH];
    logic signed [DATA_W-1:0] b_store [STORE_DEPTH];
    // Which store entries have been written since reset. A compute is only issued once
    // every entry it reads is marked, so the block never reads an undefined element.
    bit                       a_loaded [STORE_DEPTH];
    bit                       b_loaded [STORE_DEPTH];

    t_c_elem  due_elems [$];
    t_request pending_reqs [$];
    t_request offered_req;
    bit       offered = 1'b0;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;

    int due_count         = 0;
    int requests_queued   = 0;
    int requests_accepted = 0;
    int error_count       = 0;
    int quiet_cycles      = 0;
    bit progress;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int dim_of_reg(input logic [CFG_W-1:0] r);
        // A register above the store size behaves as the store size.
        return (r > MAX_DIM) ? MAX_DIM : int'(r);
    endfunction

    function automatic logic [DATA_W-1:0] element_sample();
        int                pick;
        logic [DATA_W-1:0] v;
        pick = $urandom_range(0, 9);
        v = DATA_W'($urandom);
        if (pick == 0) v = VAL_MIN;
        if (pick == 1) v = VAL_MAX;
        return v;
    endfunction

    // Sender gaps: mostly none or short, now and then a long one.
    function automatic int src_gap();
        int pick;
        if (!src_idle_en) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic int sink_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Applies one accepted request to the predictor state. A compute request queues every
    // element of C in row-major order, each as the exact dot product cut to the port width.
    function automatic void predict_request(input t_request req);
        int      nr;
        int      nk;
        int      nc;
        longint  acc;
        t_c_elem elem;
        nr = dim_of_reg(rows_reg);
        nk = dim_of_reg(inner_reg);
        nc = dim_of_reg(cols_reg);
        case (req.op)
            OP_LOAD_A: begin
                if (req.row < nr && req.col < nk) a_store[{req.row, req.col}] = req.value;
            end
            OP_LOAD_B: begin
                if (req.row < nk && req.col < nc) b_store[{req.row, req.col}] = req.value;
            end
            OP_COMPUTE: begin
                for (int i = 0; i < nr; i++) begin
                    for (int j = 0; j < nc; j++) begin
                        acc = 0;
                        for (int t = 0; t < nk; t++) begin
                            acc += longint'(a_store[i * MAX_DIM + t])
                                 * longint'(b_store[t * MAX_DIM + j]);
                        end
                        elem.row   = IDX_PORT_W'(i);
                        elem.col   = IDX_PORT_W'(j);
                        elem.value = acc[PROD_W-1:0];
                        elem.last  = (i == nr - 1) && (j == nc - 1);
                        due_elems.push_back(elem);
                        due_count++;
                    end
                end
            end
            default: begin
                // The unused operation code leaves everything as it is.
            end
        endcase
    endfunction

    function automatic void report_field(input string name, input logic signed [63:0] want,
                                         input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compares one result taken from the block with the oldest element still due.
    function automatic void check_result();
        t_c_elem due;
        if (due_count == 0) begin
            $display("%0t: result with nothing due, expected none, actual row %0d col %0d value %0d",
                     $time, o_out_row, o_out_col, o_product_value);
            error_count++;
            return;
        end
        due = due_elems.pop_front();
        due_count--;
        report_field("out_row", {61'd0, due.row}, {61'd0, o_out_row});
        report_field("out_col", {61'd0, due.col}, {61'd0, o_out_col});
        report_field("product_value", $signed(due.value), o_product_value);
        report_field("last", {63'd0, due.last}, {63'd0, o_last});
    endfunction

    // Request driver. A request stays on the port, unchanged, until it is taken; only then
    // may the next one follow, either on the very next cycle or after a random gap.
    always @(negedge i_clk) begin
        if (!offered) begin
            if (gap_left == 0 && pending_reqs.size() > 0) begin
                offered_req = pending_reqs.pop_front();
                offered = 1'b1;
                i_operation <= offered_req.op;
                i_row_index <= offered_req.row;
                i_col_index <= offered_req.col;
                i_element_value <= offered_req.value;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // Result sink. A requested hold-off is counted down here and overrides the random
    // stalls, so the block has to back up all the way to its request port.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (stall_left == 0 && sink_idle_en && $urandom_range(0, 99) < 20)
                stall_left = sink_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Everything is sampled on the rising edge: accepted requests feed the predictor,
    // accepted results are checked, and the watchdog notes whether anything moved.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_valid && !o_stall) begin
                predict_request(offered_req);
                offered = 1'b0;
                gap_left = src_gap();
                requests_accepted++;
                progress = 1'b1;
            end
            if (o_valid && !i_stall) begin
                check_result();
                progress = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) progress = 1'b1;
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, nothing accepted for %0d cycles", $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Hands one request to the driver and returns once the block has taken it. Loads that
    // land inside the current sizes mark their store entry as written.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_PORT_W-1:0] row,
                                input logic [IDX_PORT_W-1:0] col,
                                input logic [DATA_W-1:0] value);
        t_request req;
        int       ticket;
        req.op    = op;
        req.row   = row;
        req.col   = col;
        req.value = value;
        case (op)
            OP_LOAD_A: begin
                if (row < dim_of_reg(rows_reg) && col < dim_of_reg(inner_reg))
                    a_loaded[{row, col}] = 1'b1;
            end
            OP_LOAD_B: begin
                if (row < dim_of_reg(inner_reg) && col < dim_of_reg(cols_reg))
                    b_loaded[{row, col}] = 1'b1;
            end
            default: begin
            end
        endcase
        pending_reqs.push_back(req);
        requests_queued++;
        ticket = requests_queued;
        wait (requests_accepted >= ticket);
    endtask

    task automatic wait_drained();
        wait (requests_accepted == requests_queued && due_count == 0);
    endtask

    // Registers are only written with the block idle: every request taken, every result
    // back, and a few more cycles so that a trailing load has certainly settled.
    task automatic write_register(input logic [CIDX_W-1:0] index, input logic [CFG_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_ROWS_OF_A:  rows_reg  = data;
            CFG_INNER_SIZE: inner_reg = data;
            CFG_COLS_OF_B:  cols_reg  = data;
            default: begin
                // Writes beyond the register list are dropped by the block.
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                            input logic [CFG_W-1:0] cols);
        write_register(CFG_ROWS_OF_A, rows);
        write_register(CFG_INNER_SIZE, inner);
        write_register(CFG_COLS_OF_B, cols);
    endtask

    // Fills every entry of A and B that the next compute will read but that has not been
    // written since reset. An empty C reads nothing, so nothing is needed then.
    task automatic load_missing_operands();
        int nr;
        int nk;
        int nc;
        nr = dim_of_reg(rows_reg);
        nk = dim_of_reg(inner_reg);
        nc = dim_of_reg(cols_reg);
        if (nr == 0 || nc == 0) return;
        for (int i = 0; i < nr; i++)
            for (int t = 0; t < nk; t++)
                if (!a_loaded[i * MAX_DIM + t])
                    send_request(OP_LOAD_A, IDX_PORT_W'(i), IDX_PORT_W'(t), element_sample());
        for (int t = 0; t < nk; t++)
            for (int j = 0; j < nc; j++)
                if (!b_loaded[t * MAX_DIM + j])
                    send_request(OP_LOAD_B, IDX_PORT_W'(t), IDX_PORT_W'(j), element_sample());
    endtask

    task automatic compute_with_operands();
        load_missing_operands();
        send_request(OP_COMPUTE, IDX_PORT_W'($urandom), IDX_PORT_W'($urandom), element_sample());
    endtask

    // One load of A or B inside the current sizes; an empty A gives way to B, and a stray load
    // of A is sent when B is chosen this way or by chance and is empty under the present settings.
    task automatic send_random_load();
        int nr;
        int nk;
        int nc;
        nr = dim_of_reg(rows_reg);
        nk = dim_of_reg(inner_reg);
        nc = dim_of_reg(cols_reg);
        if ($urandom_range(0, 1) == 0 && nr > 0 && nk > 0)
            send_request(OP_LOAD_A, IDX_PORT_W'($urandom_range(0, nr - 1)),
                         IDX_PORT_W'($urandom_range(0, nk - 1)), element_sample());
        else if (nk > 0 && nc > 0)
            send_request(OP_LOAD_B, IDX_PORT_W'($urandom_range(0, nk - 1)),
                         IDX_PORT_W'($urandom_range(0, nc - 1)), element_sample());
        else
            send_request(OP_LOAD_A, IDX_PORT_W'($urandom), IDX_PORT_W'($urandom),
                         element_sample());
    endtask

    function automatic logic [CFG_W-1:0] random_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return '0;
        if (pick < 70) return CFG_W'($urandom_range(1, 3));
        if (pick < 85) return CFG_W'($urandom_range(4, 8));
        return CFG_W'($urandom_range(9, 15));
    endfunction

    // Largest and smallest element values, so that the products and their sum reach the
    // widest magnitudes: the first element of the second row of C gets (-32768)*(-32768) twice, i.e. 2^31.
    task automatic test_extreme_values();
        set_dims(4'd2, 4'd2, 4'd2);
        send_request(OP_LOAD_A, 3'd0, 3'd0, VAL_MIN);
        send_request(OP_LOAD_A, 3'd0, 3'd1, VAL_MAX);
        send_request(OP_LOAD_A, 3'd1, 3'd0, VAL_MIN);
        send_request(OP_LOAD_A, 3'd1, 3'd1, VAL_MIN);
        send_request(OP_LOAD_B, 3'd0, 3'd0, VAL_MIN);
        send_request(OP_LOAD_B, 3'd0, 3'd1, VAL_MAX);
        send_request(OP_LOAD_B, 3'd1, 3'd0, VAL_MIN);
        send_request(OP_LOAD_B, 3'd1, 3'd1, VAL_MAX);
        send_request(OP_COMPUTE, 3'd7, 3'd7, VAL_MAX);
    endtask

    // Loads outside the configured sizes and the unused operation must change nothing,
    // so the following compute repeats the previous matrix exactly.
    task automatic test_ignored_requests();
        send_request(OP_LOAD_A, 3'd2, 3'd0, VAL_MAX);
        send_request(OP_LOAD_A, 3'd0, 3'd7, VAL_MAX);
        send_request(OP_LOAD_B, 3'd7, 3'd7, VAL_MIN);
        send_request(OP_LOAD_B, 3'd1, 3'd2, VAL_MIN);
        send_request(OP_UNUSED, 3'd0, 3'd0, 16'hFFFF);
        send_request(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
    endtask

    // A zero row or column count leaves C empty; a zero inner size gives all-zero elements
    // whatever either store holds. The write to the spare index must leave the sizes alone.
    task automatic test_zero_dims();
        set_dims(4'd0, 4'd2, 4'd2);
        send_request(OP_COMPUTE, 3'd1, 3'd2, 16'h1234);
        set_dims(4'd2, 4'd2, 4'd0);
        send_request(OP_COMPUTE, 3'd4, 3'd3, 16'h8001);
        set_dims(4'd2, 4'd0, 4'd2);
        send_request(OP_COMPUTE, 3'd5, 3'd6, 16'h7FFE);
        write_register(CFG_SPARE_INDEX, 4'hF);
        send_request(OP_COMPUTE, 3'd2, 3'd5, 16'h5555);
    endtask

    // A row count of 15 must act as 8, giving an eight-by-one column of results.
    task automatic test_oversized_dims();
        set_dims(DIM_CEILING, 4'd1, 4'd1);
        compute_with_operands();
    endtask

    // The sink holds off long enough for the walk to block and the request port to stall
    // while loads keep arriving; then the sender waits for every result before going on.
    task automatic test_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_dims(4'd3, 4'd2, 4'd3);
        load_missing_operands();
        hold_left = HOLD_CYCLES;
        send_request(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        repeat (6) send_random_load();
        wait_drained();
        send_request(OP_COMPUTE, 3'd3, 3'd3, 16'hAAAA);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Rounds of random sizes and loads, each closed by a compute. Most loads are well formed;
    // the rest are stray indices and the unused operation. Stores keep their contents across
    // size changes, so later rounds also multiply data written under earlier settings.
    task automatic test_random_rounds();
        int                requests_at_start;
        int                pick;
        logic [CIDX_W-1:0] index;
        requests_at_start = requests_queued;
        while (requests_queued - requests_at_start < RANDOM_REQUESTS) begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                set_dims(random_dim(), random_dim(), random_dim());
            end else if (pick < 5) begin
                index = CIDX_W'($urandom_range(0, 3));
                write_register(index, random_dim());
            end
            repeat ($urandom_range(2, 10)) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_random_load();
                else if (pick < 92)
                    send_request(($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B,
                                 IDX_PORT_W'($urandom), IDX_PORT_W'($urandom), element_sample());
                else
                    send_request(OP_UNUSED, IDX_PORT_W'($urandom), IDX_PORT_W'($urandom),
                                 element_sample());
            end
            compute_with_operands();
            // Now and then a second compute straight behind the first.
            if ($urandom_range(0, 4) == 0)
                send_request(OP_COMPUTE, IDX_PORT_W'($urandom), IDX_PORT_W'($urandom),
                             element_sample());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_LOAD_A;
        i_row_index     = '0;
        i_col_index     = '0;
        i_element_value = '0;
        i_stall         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_ROWS_OF_A;
        i_cfg_data      = '0;
        rows_reg        = CFG_RESET;
        inner_reg       = CFG_RESET;
        cols_reg        = CFG_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_values();
        test_ignored_requests();
        test_zero_dims();
        test_oversized_dims();
        test_backpressure();
        test_random_rounds();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/imm_pkg.sv
rtl/imm_store.sv
rtl/imm_seq.sv
rtl/imm_mac.sv
rtl/integer_matrix_multiply.sv
tb/sv/integer_matrix_multiply_tb.sv
